/* design/dkef_pkg.sv */
// Shared types and constants for the debounced key event FIFO.
// No dependencies; imported by every module of the block.
package dkef_pkg;

	localparam int TICK_W     = 32;
	localparam int DEBOUNCE_W = 16;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd20;

	// request opcodes
	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic              op;
		logic [TICK_W-1:0] now_tick;
		logic              level;
	} req_t;

	typedef struct packed {
		logic              edge_accepted;
		logic              event_dropped;
		logic              read_valid;
		logic              read_state;
		logic              events_waiting;
		logic              led_drive;
		logic [TICK_W-1:0] drop_total;
	} rsp_t;

	// control from the top level into the ring
	typedef struct packed {
		logic step;   // request moves into the result register this cycle
		logic push;   // accepted key edge
		logic pop;    // read request
		logic level;  // key level to store
	} ring_ctl_t;

	// ring status for the request in flight
	typedef struct packed {
		logic dropped;
		logic rd_ok;
		logic waiting;
	} ring_sts_t;

endpackage

/* design/debounced_key_event_fifo.sv */
// Top level of the debounced key event FIFO: request register, result register
// and handshakes. Depends on dkef_pkg, dkef_debounce and dkef_ring.

// Each request is either a key edge or a read. A key edge is kept when its tick
// is not before the last kept tick plus debounce_ticks (signed 32-bit wrap
// compare) and its level differs from the last kept level; a kept edge sets
// the LED to the inverted level and is pushed into a QUEUE_DEPTH-slot ring
// that leaves one slot free, so QUEUE_DEPTH-1 events fit. A push into a full
// ring is dropped and counted in drop_total. A read pops the oldest event or
// reports an empty ring. Exactly one response is produced per request.
// Throughput: one request per clock unless rsp_ready holds off the result
// register. A request passes through the request register and then the result
// register, where its response becomes valid; the debounce compare, pointer
// update and event memory access all sit in the single stage between them.
// The event memory is not cleared after reset and needs no clearing pass; only
// entries already written are ever read.
// cfg_we writes debounce_ticks (reset 20) and is meant for idle periods only.
module debounced_key_event_fifo #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dkef_pkg::DEBOUNCE_W-1:0]   cfg_wdata,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  dkef_pkg::req_t                    req,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output dkef_pkg::rsp_t                    rsp
);
	import dkef_pkg::*;

	// request register
	logic  valid_s1;
	req_t  req_s1;
	logic  adv;          // request moves into the result register

	// result register
	logic              valid_s2;
	logic              acc_s2, drop_s2, rvalid_s2, wait_s2, led_s2;
	logic [TICK_W-1:0] total_s2;
	logic              rd_state_s2;

	logic              accept, led_next;
	ring_ctl_t         ring_ctl;
	ring_sts_t         ring_sts;
	logic [TICK_W-1:0] drop_total;

	// result register frees up when empty or being drained
	assign adv       = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	dkef_debounce u_debounce (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (adv),
		.item      (req_s1),
		.accept    (accept),
		.led_next  (led_next)
	);

	assign ring_ctl.step  = adv;
	assign ring_ctl.push  = accept;
	assign ring_ctl.pop   = (req_s1.op == OP_READ);
	assign ring_ctl.level = req_s1.level;

	dkef_ring #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_ring (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ring_ctl),
		.sts         (ring_sts),
		.drop_total  (drop_total),
		.rd_state_s2 (rd_state_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (rsp_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s2    <= accept;
			drop_s2   <= ring_sts.dropped;
			rvalid_s2 <= ring_sts.rd_ok;
			wait_s2   <= ring_sts.waiting;
			led_s2    <= led_next;
			total_s2  <= drop_total;
		end
	end

	assign rsp_valid          = valid_s2;
	assign rsp.edge_accepted  = acc_s2;
	assign rsp.event_dropped  = drop_s2;
	assign rsp.read_valid     = rvalid_s2;
	assign rsp.read_state     = rd_state_s2;
	assign rsp.events_waiting = wait_s2;
	assign rsp.led_drive      = led_s2;
	assign rsp.drop_total     = total_s2;

	// a full ring can never look empty after a drop
	a_drop_keeps_events: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ring_sts.dropped |-> ring_sts.waiting)
		else $error("drop reported with empty ring");

	// a drop changes the reported drop counter
	a_drop_counts: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ring_sts.dropped |=> rsp.drop_total != $past(rsp.drop_total)
		|| !$past(valid_s2))
		else $error("drop counter did not move on drop");

	// edge and read results never mix
	a_op_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (rvalid_s2 || rd_state_s2) |-> !acc_s2 && !drop_s2)
		else $error("read and edge result in one response");

	// stalled request register holds its contents
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(req_s1))
		else $error("request register lost a stalled request");

	// back-pressure only when both registers are full and blocked
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> valid_s1 && valid_s2 && !rsp_ready)
		else $error("request side stalled without cause");

endmodule

/* design/dkef_debounce.sv */
// Debounce and level-change filter with the last accepted edge and LED state.
// Depends on dkef_pkg.
module dkef_debounce (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [dkef_pkg::DEBOUNCE_W-1:0]    cfg_wdata,
	input  logic                               step,
	input  dkef_pkg::req_t                     item,
	output logic                               accept,
	output logic                               led_next
);
	import dkef_pkg::*;

	logic [DEBOUNCE_W-1:0] debounce_q;
	logic [TICK_W-1:0]     last_tick_q;
	logic [TICK_W-1:0]     limit_q;      // last_tick_q + debounce_q, kept ready
	logic                  prev_level_q;
	logic                  led_q;
	logic [TICK_W-1:0]     diff;

	// wrap-safe: edge is early when now - limit is negative
	assign diff     = item.now_tick - limit_q;
	assign accept   = (item.op == OP_EDGE) && !diff[TICK_W-1] && (item.level != prev_level_q);
	assign led_next = accept ? ~item.level : led_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RESET;
			last_tick_q  <= '0;
			limit_q      <= TICK_W'(DEBOUNCE_RESET);
			prev_level_q <= 1'b0;
			led_q        <= 1'b0;
		end else if (cfg_we) begin
			debounce_q <= cfg_wdata;
			limit_q    <= last_tick_q + TICK_W'(cfg_wdata);
		end else if (step && accept) begin
			last_tick_q  <= item.now_tick;
			limit_q      <= item.now_tick + TICK_W'(debounce_q);
			prev_level_q <= item.level;
			led_q        <= ~item.level;
		end
	end

endmodule

/* design/dkef_ring.sv */
// Event ring: pointers, one-bit event memory and wrapping drop counter.
// Depends on dkef_pkg.
module dkef_ring #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dkef_pkg::ring_ctl_t           ctl,
	output dkef_pkg::ring_sts_t           sts,
	output logic [dkef_pkg::TICK_W-1:0]   drop_total,
	output logic                          rd_state_s2
);
	import dkef_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

	logic             mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q, wp_inc, rp_inc, wp_next, rp_next;
	logic [TICK_W-1:0] drop_q;
	logic             full, do_push;

	assign wp_inc  = (wp_q == LAST) ? '0 : wp_q + 1'b1;
	assign rp_inc  = (rp_q == LAST) ? '0 : rp_q + 1'b1;
	assign full    = (wp_inc == rp_q);   // one slot always left empty

	assign do_push     = ctl.push && !full;
	assign sts.dropped = ctl.push && full;
	assign sts.rd_ok   = ctl.pop && (wp_q != rp_q);
	assign wp_next     = do_push ? wp_inc : wp_q;
	assign rp_next     = sts.rd_ok ? rp_inc : rp_q;
	assign sts.waiting = (wp_next != rp_next);
	assign drop_total  = drop_q + TICK_W'(sts.dropped);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			drop_q <= '0;
		end else if (ctl.step) begin
			wp_q   <= wp_next;
			rp_q   <= rp_next;
			drop_q <= drop_total;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step && do_push) begin
			mem[wp_q] <= ctl.level;
		end
	end

	// registered read port, lands with the rest of the result
	always_ff @(posedge clk) begin
		if (ctl.step) begin
			rd_state_s2 <= sts.rd_ok ? mem[rp_q] : 1'b0;
		end
	end

endmodule
